// ----- src/dac_variable_chunk_store_assert.svh -----
// ----------------------------------------------------------------------------
// dac_variable_chunk_store_assert
// Assertion macros for the variable chunk store.
// ----------------------------------------------------------------------------
`ifndef DAC_VARIABLE_CHUNK_STORE_ASSERT_SVH
`define DAC_VARIABLE_CHUNK_STORE_ASSERT_SVH

// Same-cycle implication.
`define DVCS_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dvcs check failed");

// Next-cycle implication.
`define DVCS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dvcs check failed");

`endif

// ----- src/dvcs_pkg.sv -----
// ----------------------------------------------------------------------------
// dvcs_pkg
// Types, codes and helpers for the variable chunk store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dvcs_pkg;

   localparam int DEF_MAX_ITEMS  = 1024;
   localparam int DEF_MAX_LEVELS = 8;
   localparam int CHUNK_W        = 8;
   localparam int CSR_IW         = 2;

   localparam logic [31:0] WIDTHS_RESET = 32'h4444_4444;
   localparam logic [3:0]  LEVELS_RESET = 4'd8;

   localparam logic [CSR_IW-1:0] CSR_CHUNK_WIDTHS = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_LEVELS_IN_USE = 2'd1;

   localparam logic [1:0] FN_APPEND = 2'd0;
   localparam logic [1:0] FN_READ   = 2'd1;
   localparam logic [1:0] FN_CLEAR  = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_TOO_LARGE = 2'd1;
   localparam logic [1:0] STAT_BAD_INDEX = 2'd2;
   localparam logic [1:0] STAT_FULL      = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OFFS,
      ST_APP_CHK,
      ST_APP_WR,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] value;
      logic [10:0] index;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [1:0]  status;
   } rsp_type;

   // chunk width of a level, clamped to 1..8
   function automatic logic [3:0] width_of(input logic [31:0] cw, input logic [2:0] lvl);
      logic [3:0] w;
      w = cw[{lvl, 2'b00} +: 4];
      if (w < 4'd1) w = 4'd1;
      if (w > 4'd8) w = 4'd8;
      return w;
   endfunction

   function automatic logic [3:0] levels_used(input logic [3:0] lu, input logic [3:0] maxl);
      logic [3:0] n;
      n = lu;
      if (n < 4'd1) n = 4'd1;
      if (n > maxl) n = maxl;
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- src/dac_variable_chunk_store.sv -----
// Compressed integer store, directly addressable codes with a chunk width per
// level. One request at a time; req_ready is high only while idle. An append
// runs the level offset pass, one check state, one write state per level
// written and a state that posts the response; a rejected append skips the
// writes. A read runs the offset pass, then for each level walked a memory
// address state and a registered data state, then posts the response. Clear,
// unused codes and out of range indexes go straight to posting. After the
// response is posted the store returns to idle and accepts the next request,
// and posting waits while an earlier response is still held off by
// rsp_ready. The walk is sequential because of the single chunk memory port
// and the shared offset adder. Each memory word carries the chunk, its stop
// bit and the count of stops before it in its level, so the per-level rank
// is one read.
// ----------------------------------------------------------------------------
// dac_variable_chunk_store
// Variable chunk width DAC store with append, indexed read and clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dac_variable_chunk_store #(
   parameter int MAX_ITEMS  = dvcs_pkg::DEF_MAX_ITEMS,
   parameter int MAX_LEVELS = dvcs_pkg::DEF_MAX_LEVELS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire dvcs_pkg::req_type            req_payload,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      dvcs_pkg::rsp_type            rsp_payload,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [dvcs_pkg::CSR_IW-1:0]  csr_index,
   input  wire logic [31:0]                  csr_data
);
   import dvcs_pkg::*;

   localparam int PW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int FW    = $clog2(MAX_ITEMS + 1);
   localparam int CW    = (FW > 11) ? FW : 11;
   localparam int LVW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int DEPTH = MAX_LEVELS * MAX_ITEMS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MW    = PW + 1 + CHUNK_W;
   localparam logic [3:0] MAXL = 4'(MAX_LEVELS);

   // memory word: {rank, stop, chunk}
   logic [MW-1:0] mem [DEPTH];
   logic [MW-1:0] mem_q;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [MW-1:0] mem_wdata;

   state_type state_ff, state_in;
   logic [31:0] widths_ff, widths_in;
   logic [3:0]  levels_ff, levels_in;
   logic [FW-1:0] fill_ff  [MAX_LEVELS];
   logic [FW-1:0] fill_in  [MAX_LEVELS];
   logic [FW-1:0] stops_ff [MAX_LEVELS];
   logic [FW-1:0] stops_in [MAX_LEVELS];
   logic [31:0] off_lo_ff [MAX_LEVELS];
   logic [31:0] off_lo_in [MAX_LEVELS];
   logic [1:0]  func_ff, func_in;
   logic [31:0] value_ff, value_in;
   logic [LVW-1:0] lvl_ff, lvl_in, jsel_ff, jsel_in;
   logic [57:0] off_ff, off_in;
   logic [56:0] prod_ff, prod_in;
   logic [6:0]  bits_ff, bits_in, bitsel_ff, bitsel_in;
   logic [31:0] offsel_ff, offsel_in;
   logic [31:0] rem_ff, rem_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [6:0]  mult_ff, mult_in;
   logic [31:0] sum_ff, sum_in;
   logic [31:0] res_value_ff, res_value_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [3:0]    n_used;
   logic [3:0]    w_cur;
   logic [7:0]    wmask;
   logic [CW-1:0] idx_c, fill0_c;
   logic [56:0]   prod_next;
   logic [31:0]   r_val;
   logic [7:0]    chunk_c;
   logic [31:0]   term;
   logic [31:0]   sum_new;
   logic          last_lvl;

   function automatic logic [AW-1:0] slot_addr(input logic [LVW-1:0] l,
                                               input logic [PW-1:0] p);
      return AW'(AW'(l) * AW'(MAX_ITEMS) + AW'(p));
   endfunction

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         widths_ff    <= WIDTHS_RESET;
         levels_ff    <= LEVELS_RESET;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            fill_ff[i]  <= '0;
            stops_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         widths_ff    <= widths_in;
         levels_ff    <= levels_in;
         fill_ff      <= fill_in;
         stops_ff     <= stops_in;
      end
      off_lo_ff     <= off_lo_in;
      func_ff       <= func_in;
      value_ff      <= value_in;
      lvl_ff        <= lvl_in;
      jsel_ff       <= jsel_in;
      off_ff        <= off_in;
      prod_ff       <= prod_in;
      bits_ff       <= bits_in;
      bitsel_ff     <= bitsel_in;
      offsel_ff     <= offsel_in;
      rem_ff        <= rem_in;
      pos_ff        <= pos_in;
      mult_ff       <= mult_in;
      sum_ff        <= sum_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      widths_in     = widths_ff;
      levels_in     = levels_ff;
      fill_in       = fill_ff;
      stops_in      = stops_ff;
      off_lo_in     = off_lo_ff;
      func_in       = func_ff;
      value_in      = value_ff;
      lvl_in        = lvl_ff;
      jsel_in       = jsel_ff;
      off_in        = off_ff;
      prod_in       = prod_ff;
      bits_in       = bits_ff;
      bitsel_in     = bitsel_ff;
      offsel_in     = offsel_ff;
      rem_in        = rem_ff;
      pos_in        = pos_ff;
      mult_in       = mult_ff;
      sum_in        = sum_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_raddr     = '0;
      req_ready     = (state_ff == ST_IDLE);

      n_used    = levels_used(levels_ff, MAXL);
      w_cur     = width_of(widths_ff, 3'(lvl_ff));
      wmask     = 8'((9'd1 << w_cur) - 9'd1);
      last_lvl  = (5'(lvl_ff) + 5'd1) >= 5'(n_used);
      idx_c     = CW'(req_payload.index);
      fill0_c   = CW'(fill_ff[0]);
      prod_next = prod_ff << w_cur;
      r_val     = value_ff - offsel_ff;
      chunk_c   = mem_q[CHUNK_W-1:0] & wmask;
      term      = (mult_ff < 7'd32) ? (32'(chunk_c) << mult_ff[4:0]) : 32'd0;
      sum_new   = sum_ff + term;

      if (csr_valid) begin
         if (csr_index == CSR_CHUNK_WIDTHS) begin
            widths_in = csr_data;
         end else if (csr_index == CSR_LEVELS_IN_USE) begin
            levels_in = csr_data[3:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in       = req_payload.func;
               value_in      = req_payload.value;
               pos_in        = PW'(idx_c - CW'(1));
               lvl_in        = '0;
               jsel_in       = '0;
               off_in        = '0;
               prod_in       = 57'd1;
               bits_in       = '0;
               bitsel_in     = '0;
               offsel_in     = '0;
               sum_in        = '0;
               mult_in       = '0;
               res_value_in  = '0;
               res_status_in = STAT_OK;
               case (req_payload.func)
                  FN_APPEND: state_in = ST_OFFS;
                  FN_READ: begin
                     if (idx_c == '0 || idx_c > fill0_c) begin
                        res_status_in = STAT_BAD_INDEX;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_OFFS;
                     end
                  end
                  FN_CLEAR: begin
                     for (int i = 0; i < MAX_LEVELS; i++) begin
                        fill_in[i]  = '0;
                        stops_in[i] = '0;
                     end
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_OFFS: begin
            // offsets rise with the level, so the last hit is the highest
            if (off_ff <= 58'(value_ff)) begin
               jsel_in   = lvl_ff;
               offsel_in = off_ff[31:0];
               bitsel_in = bits_ff + 7'(w_cur);
            end
            off_lo_in[lvl_ff] = off_ff[31:0];
            prod_in = prod_next;
            off_in  = off_ff + 58'(prod_next);
            bits_in = bits_ff + 7'(w_cur);
            if (last_lvl) begin
               lvl_in   = '0;
               state_in = (func_ff == FN_APPEND) ? ST_APP_CHK : ST_RD_ADDR;
            end else begin
               lvl_in = lvl_ff + LVW'(1);
            end
         end
         ST_APP_CHK: begin
            if (fill_ff[0] >= FW'(MAX_ITEMS)) begin
               res_status_in = STAT_FULL;
               state_in      = ST_DONE;
            end else if (bitsel_ff < 7'd32 && (r_val >> bitsel_ff) != 32'd0) begin
               res_status_in = STAT_TOO_LARGE;
               state_in      = ST_DONE;
            end else begin
               rem_in   = r_val;
               state_in = ST_APP_WR;
            end
         end
         ST_APP_WR: begin
            mem_we    = 1'b1;
            mem_waddr = slot_addr(lvl_ff, PW'(fill_ff[lvl_ff]));
            mem_wdata = {PW'(stops_ff[lvl_ff]), (lvl_ff == jsel_ff), rem_ff[7:0] & wmask};
            fill_in[lvl_ff] = fill_ff[lvl_ff] + FW'(1);
            rem_in = rem_ff >> w_cur;
            if (lvl_ff == jsel_ff) begin
               stops_in[lvl_ff] = stops_ff[lvl_ff] + FW'(1);
               state_in = ST_DONE;
            end else begin
               lvl_in = lvl_ff + LVW'(1);
            end
         end
         ST_RD_ADDR: begin
            mem_raddr = slot_addr(lvl_ff, pos_ff);
            state_in  = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            if (mem_q[CHUNK_W] || last_lvl) begin
               res_value_in = sum_new + off_lo_ff[lvl_ff];
               state_in     = ST_DONE;
            end else begin
               sum_in   = sum_new;
               pos_in   = pos_ff - mem_q[MW-1 -: PW];
               mult_in  = mult_ff + 7'(w_cur);
               lvl_in   = lvl_ff + LVW'(1);
               state_in = ST_RD_ADDR;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.read_value = res_value_ff;
               rsp_data_in.status     = res_status_ff;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`include "dac_variable_chunk_store_assert.svh"

   `DVCS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `DVCS_ASSERT_SAME(a_err_zero_value, clock, reset, rsp_valid && rsp_payload.status != STAT_OK, rsp_payload.read_value == 32'd0)
   `DVCS_ASSERT_SAME(a_fill_order, clock, reset, 1'b1, fill_ff[MAX_LEVELS-1] <= fill_ff[0])

endmodule

`default_nettype wire

// ----- verif/dac_variable_chunk_store_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_variable_chunk_store_tb
// Self-checking bench for the variable chunk width DAC store. A directed table
// covers empty reads, extreme values, rejects and clamped settings. Random
// traffic then fills the store to capacity and runs several chunk width /
// level settings. Each response is checked against the table or a local model.
// ----------------------------------------------------------------------------
module dac_variable_chunk_store_tb;
   import dvcs_pkg::*;

   localparam int          NITEMS     = 1024;
   localparam int          NLEVELS    = 8;
   localparam int          IDLE_LIMIT = 4000;
   localparam logic [1:0]  FN_UNUSED  = 2'd3;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      req_type           req;
      bit                typed;
      rsp_type           rsp;
      logic [CSR_IW-1:0] csr_idx;
      logic [31:0]       csr_val;
   } row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [31:0]       csr_data = '0;

   // local copy of the store
   logic [7:0]  chunk_mem [NLEVELS][NITEMS];
   bit          stop_mem  [NLEVELS][NITEMS];
   int          fill      [NLEVELS];
   logic [31:0] width_cfg = WIDTHS_RESET;
   logic [3:0]  level_cfg = LEVELS_RESET;

   rsp_type pending_rsp[$];
   int      errors = 0;
   int      idle_cycles = 0;
   bit      quiet = 1'b0;
   int      stall_left = 0;
   row_type rows[$];

   dac_variable_chunk_store DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int lvl_width(int lvl);
      int w;
      w = width_cfg[4*lvl +: 4];
      if (w < 1) w = 1;
      if (w > 8) w = 8;
      return w;
   endfunction

   function automatic int lvl_count();
      int n;
      n = level_cfg;
      if (n < 1) n = 1;
      if (n > NLEVELS) n = NLEVELS;
      return n;
   endfunction

   function automatic rsp_type store_access(req_type r);
      rsp_type     o;
      logic [63:0] off [NLEVELS];
      logic [63:0] prod, rem, sum, c;
      int          n, j, k, bits, w, pos, mult, stops;
      o = '0;
      o.status = STAT_OK;
      n = lvl_count();
      prod = 64'd1;
      off[0] = 64'd0;
      for (k = 0; k + 1 < n; k++) begin
         prod = prod << lvl_width(k);
         off[k+1] = off[k] + prod;
      end
      case (r.func)
         FN_APPEND: begin
            if (fill[0] >= NITEMS) begin
               o.status = STAT_FULL;
            end else begin
               j = n - 1;
               while (j > 0 && off[j] > {32'd0, r.value}) j--;
               rem = {32'd0, r.value} - off[j];
               bits = 0;
               for (k = 0; k <= j; k++) bits += lvl_width(k);
               if (bits < 64 && (rem >> bits) != 0) begin
                  o.status = STAT_TOO_LARGE;
               end else begin
                  for (k = 0; k <= j; k++) begin
                     w = lvl_width(k);
                     chunk_mem[k][fill[k] % NITEMS] = rem[7:0] & ((8'd1 << w) - 8'd1);
                     stop_mem[k][fill[k] % NITEMS] = (k == j);
                     fill[k]++;
                     rem = rem >> w;
                  end
               end
            end
         end
         FN_READ: begin
            if (r.index == 0 || r.index > fill[0]) begin
               o.status = STAT_BAD_INDEX;
            end else begin
               pos = r.index - 1;
               j = 0;
               mult = 0;
               sum = 64'd0;
               forever begin
                  c = {56'd0, chunk_mem[j][pos] & ((8'd1 << lvl_width(j)) - 8'd1)};
                  sum += c << mult;
                  if (stop_mem[j][pos] || j + 1 >= n) break;
                  stops = 0;
                  for (k = 0; k < pos; k++) stops += stop_mem[j][k];
                  pos -= stops;
                  mult += lvl_width(j);
                  j++;
               end
               sum = sum + off[j];
               o.read_value = sum[31:0];
            end
         end
         FN_CLEAR: begin
            for (k = 0; k < NLEVELS; k++) fill[k] = 0;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic int gap_len();
      int p;
      if (quiet) return 0;
      p = $urandom_range(0, 99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type rand_request(int app_pct, int read_pct, int clr_pct);
      req_type r;
      int      p, top;
      r.value = $urandom;
      r.index = 11'($urandom);
      p = $urandom_range(0, 99);
      if (p < app_pct) r.func = FN_APPEND;
      else if (p < app_pct + read_pct) r.func = FN_READ;
      else if (p < app_pct + read_pct + clr_pct) r.func = FN_CLEAR;
      else r.func = FN_UNUSED;
      case ($urandom_range(0, 5))
         0: r.value = $urandom_range(0, 255);
         1: r.value = $urandom_range(0, 70000);
         2: r.value = 32'd1 << $urandom_range(0, 31);
         3: r.value = 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: ;
      endcase
      top = (fill[0] < 1) ? 1 : fill[0];
      p = $urandom_range(0, 99);
      if (p < 85) r.index = 11'($urandom_range(1, top));
      else if (p < 90) r.index = 11'(fill[0] + 1);
      else if (p < 95) r.index = 11'd0;
      return r;
   endfunction

   task automatic send_request(req_type r, bit typed, rsp_type typed_rsp);
      int      g;
      rsp_type p;
      g = gap_len();
      @(negedge clock);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      p = store_access(r);
      pending_rsp.push_back(typed ? typed_rsp : p);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IW-1:0] idx, logic [31:0] val);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_CHUNK_WIDTHS) width_cfg = val;
      else if (idx == CSR_LEVELS_IN_USE) level_cfg = val[3:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_req(logic [1:0] f, logic [31:0] v, logic [10:0] i,
                                   bit typed = 0, logic [31:0] rv = 0,
                                   logic [1:0] st = STAT_OK);
      row_type w;
      w.kind = ROW_REQ;
      w.req.func = f;
      w.req.value = v;
      w.req.index = i;
      w.typed = typed;
      w.rsp.read_value = rv;
      w.rsp.status = st;
      rows.push_back(w);
   endfunction

   function automatic void add_csr(logic [CSR_IW-1:0] idx, logic [31:0] val);
      row_type w;
      w.kind = ROW_CSR;
      w.req = '0;
      w.typed = 1'b0;
      w.rsp = '0;
      w.csr_idx = idx;
      w.csr_val = val;
      rows.push_back(w);
   endfunction

   // response side: random stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         stall_left <= gap_len();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("dac_variable_chunk_store_tb: errors");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected response value=%h status=%0d",
                           rsp_payload.read_value, rsp_payload.status);
            end else begin
               if (rsp_payload.read_value !== pending_rsp[0].read_value ||
                   rsp_payload.status !== pending_rsp[0].status) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp value=%h status=%0d got value=%h status=%0d",
                              pending_rsp[0].read_value, pending_rsp[0].status,
                              rsp_payload.read_value, rsp_payload.status);
               end
               void'(pending_rsp.pop_front());
            end
         end
      end
   end

   initial begin
      int          i, ph, extra;
      req_type     r;
      logic [31:0] cfg_w [6];
      logic [31:0] cfg_l [6];
      for (i = 0; i < NLEVELS; i++) fill[i] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      add_req(FN_READ, 32'd0, 11'd1, 1, 32'd0, STAT_BAD_INDEX);
      add_req(FN_READ, 32'd0, 11'd0, 1, 32'd0, STAT_BAD_INDEX);
      add_req(FN_APPEND, 32'd0, 11'd0, 1, 32'd0, STAT_OK);
      add_req(FN_APPEND, 32'hFFFF_FFFF, 11'h7FF, 1, 32'd0, STAT_OK);
      add_req(FN_APPEND, 32'd15, 11'd0);
      add_req(FN_APPEND, 32'd16, 11'd0);
      add_req(FN_APPEND, 32'd272, 11'd0);
      add_req(FN_READ, 32'd0, 11'd1, 1, 32'd0, STAT_OK);
      add_req(FN_READ, 32'hFFFF_FFFF, 11'd2, 1, 32'hFFFF_FFFF, STAT_OK);
      add_req(FN_READ, 32'd0, 11'd3);
      add_req(FN_READ, 32'd0, 11'd4);
      add_req(FN_READ, 32'd0, 11'd5);
      add_req(FN_READ, 32'd0, 11'd6, 1, 32'd0, STAT_BAD_INDEX);
      add_req(FN_UNUSED, 32'hFFFF_FFFF, 11'h7FF, 1, 32'd0, STAT_OK);
      add_req(FN_CLEAR, 32'd0, 11'd0, 1, 32'd0, STAT_OK);
      add_req(FN_READ, 32'd0, 11'd1, 1, 32'd0, STAT_BAD_INDEX);
      add_csr(CSR_CHUNK_WIDTHS, 32'h1111_1111);
      add_csr(CSR_LEVELS_IN_USE, 32'd1);
      add_req(FN_APPEND, 32'd1, 11'd0, 1, 32'd0, STAT_OK);
      add_req(FN_APPEND, 32'd2, 11'd0, 1, 32'd0, STAT_TOO_LARGE);
      add_req(FN_READ, 32'd0, 11'd1, 1, 32'd1, STAT_OK);
      // zero nibble and zero level count clamp to one
      add_csr(CSR_CHUNK_WIDTHS, 32'h0000_0000);
      add_csr(CSR_LEVELS_IN_USE, 32'd0);
      add_req(FN_APPEND, 32'd2, 11'd0, 1, 32'd0, STAT_TOO_LARGE);
      // oversized nibbles and level count clamp to eight
      add_csr(CSR_CHUNK_WIDTHS, 32'hFFFF_FFFF);
      add_csr(CSR_LEVELS_IN_USE, 32'hFFFF_FFFF);
      add_req(FN_APPEND, 32'hFFFF_FFFF, 11'd0);
      add_req(FN_APPEND, 32'd300, 11'd0);
      add_req(FN_READ, 32'd0, 11'd2);
      // shrink levels: walks stop early on old data
      add_csr(CSR_LEVELS_IN_USE, 32'd2);
      add_req(FN_READ, 32'd0, 11'd2);
      add_req(FN_READ, 32'd0, 11'd3);

      foreach (rows[k]) begin
         if (rows[k].kind == ROW_CSR)
            write_csr(rows[k].csr_idx, rows[k].csr_val);
         else
            send_request(rows[k].req, rows[k].typed, rows[k].rsp);
      end

      // fill to capacity with default-like widths, then push past full
      write_csr(CSR_CHUNK_WIDTHS, WIDTHS_RESET);
      write_csr(CSR_LEVELS_IN_USE, 32'd8);
      i = 0;
      extra = 0;
      while (extra < 30) begin
         if (i == 500) drain();
         r = rand_request(90, 9, 0);
         send_request(r, 0, '0);
         if (fill[0] >= NITEMS) extra++;
         i++;
      end

      cfg_w[0] = 32'h8888_8888; cfg_l[0] = 32'd8;
      cfg_w[1] = 32'h1111_1111; cfg_l[1] = 32'd1;
      cfg_w[2] = 32'h0F0F_0F0F; cfg_l[2] = 32'd0;
      cfg_w[3] = 32'hFFFF_FFFF; cfg_l[3] = 32'd15;
      cfg_w[4] = 32'h1234_5678; cfg_l[4] = 32'd4;
      cfg_w[5] = $urandom;      cfg_l[5] = $urandom;
      for (ph = 0; ph < 6; ph++) begin
         quiet = (ph == 2);
         write_csr(CSR_CHUNK_WIDTHS, cfg_w[ph]);
         write_csr(CSR_LEVELS_IN_USE, cfg_l[ph]);
         // old contents under the new setting
         for (i = 0; i < 8; i++) send_request(rand_request(0, 100, 0), 0, '0);
         r = rand_request(0, 0, 100);
         send_request(r, 0, '0);
         for (i = 0; i < 40; i++) send_request(rand_request(55, 37, 4), 0, '0);
      end
      quiet = 1'b0;

      drain();
      repeat (40) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         errors++;
         $display("%0d responses never arrived", pending_rsp.size());
      end
      if (errors == 0)
         $display("dac_variable_chunk_store_tb: clean");
      else
         $display("dac_variable_chunk_store_tb: errors");
      $finish;
   end

endmodule
